[sv/assert_macros.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define RFWT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next.
`define RFWT_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

[sv/rfwt_pkg.sv]
`timescale 1ns / 1ps

package rfwt_pkg;

    localparam int unsigned FREQ_W    = 24;
    localparam int unsigned EDGE_W    = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned STEP_W    = 13;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP = 1'd1;

    localparam logic [TIME_W-1:0] TIMEOUT_MS_RESET   = 32'd240000;
    localparam logic [STEP_W-1:0] INITIAL_STEP_RESET = 13'd16;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_BEGIN = 3'd1,
        PH_WAIT  = 3'd2,
        PH_CHOP  = 3'd3,
        PH_ABORT = 3'd4,
        PH_STOP  = 3'd5
    } t_phase;

    typedef struct packed {
        t_phase                     phase;
        logic                       enabled;
        logic [FREQ_W-1:0]          origin_freq;
        logic [FREQ_W-1:0]          current_freq;
        logic signed [EDGE_W-1:0]   outer_edge;
        logic signed [EDGE_W-1:0]   inner_edge;
        logic signed [EDGE_W-1:0]   step_signed;
        logic signed [EDGE_W-1:0]   low_limit;
        logic signed [EDGE_W-1:0]   high_limit;
        logic [FREQ_W-1:0]          issued_freq;
        logic [TIME_W-1:0]          last_valid_time;
    } t_state;

    typedef struct packed {
        logic                       active;
        logic                       changed;
        logic [FREQ_W-1:0]          freq;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:           PH_IDLE,
        enabled:         1'b0,
        origin_freq:     '0,
        current_freq:    '0,
        outer_edge:      '0,
        inner_edge:      '0,
        step_signed:     '0,
        low_limit:       '0,
        high_limit:      '0,
        issued_freq:     '0,
        last_valid_time: '0
    };

    function automatic logic signed [EDGE_W:0] sx17(input logic signed [EDGE_W-1:0] v);
        return {v[EDGE_W-1], v};
    endfunction

    // Signed halving that rounds toward zero.
    function automatic logic signed [EDGE_W:0] div2(input logic signed [EDGE_W:0] x);
        logic signed [EDGE_W:0] t;
        t = x + signed'({{EDGE_W{1'b0}}, x[EDGE_W]});
        return t >>> 1;
    endfunction

    function automatic logic [FREQ_W-1:0] fadd(input logic [FREQ_W-1:0] f,
                                               input logic signed [EDGE_W:0] d);
        return f + {{(FREQ_W-EDGE_W-1){d[EDGE_W]}}, d};
    endfunction

endpackage

[sv/radio_frequency_window_tuner_unit.sv]
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser kind, tdata item
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata result
// cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One item is taken every cycle while the result is not stalled; each item passes through
// the input register and then the result register before its result beat can complete.
// The input register feeds the step logic, which updates the state and the result register
// in the same cycle, so consecutive items see each other's state without a gap.
// Reset clears the tuning state and loads the register defaults.
// A stalled result holds the result register; the input register then fills and
// s_axis_tready drops until the result beat completes.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module radio_frequency_window_tuner_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [23:0] start_freq, [24] msg_valid, [56:25] now_ms, [63:57] zero
    input  logic [63:0]                         s_axis_tdata,
    // [1:0] kind
    input  logic [rfwt_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [23:0] freq, [24] freq_changed, [25] tuning_active, [31:26] zero
    output logic [31:0]                         m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rfwt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rfwt_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import rfwt_pkg::*;

    logic                   r_in_valid;
    logic [KIND_W-1:0]      r_kind;
    logic [FREQ_W-1:0]      r_start_freq;
    logic                   r_msg_valid;
    logic [TIME_W-1:0]      r_now_ms;
    logic                   r_out_valid;
    t_result                r_out;
    t_state                 r_state;
    logic [TIME_W-1:0]      r_timeout_ms;
    logic [STEP_W-1:0]      r_initial_step;

    t_state                 n_state;
    t_result                n_out;
    logic                   w_in_fire;
    logic                   w_load_out;

    assign w_load_out    = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_load_out;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_out.active, r_out.changed, r_out.freq};

    rfwt_core u_core (
        .i_state        (r_state),
        .i_kind         (r_kind),
        .i_start_freq   (r_start_freq),
        .i_msg_valid    (r_msg_valid),
        .i_now_ms       (r_now_ms),
        .i_timeout_ms   (r_timeout_ms),
        .i_initial_step (r_initial_step),
        .o_state        (n_state),
        .o_result       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_load_out) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_kind       <= s_axis_tuser;
            r_start_freq <= s_axis_tdata[23:0];
            r_msg_valid  <= s_axis_tdata[24];
            r_now_ms     <= s_axis_tdata[56:25];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
            r_state     <= n_state;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms   <= TIMEOUT_MS_RESET;
            r_initial_step <= INITIAL_STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TIMEOUT_MS:   r_timeout_ms   <= i_cfg_data;
                REG_INITIAL_STEP: r_initial_step <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    `RFWT_ASSERT(a_idle_when_disabled, !r_state.enabled |-> r_state.phase == PH_IDLE,
                 "disabled tuner left idle phase")
    `RFWT_ASSERT(a_change_only_active, r_out_valid && r_out.changed |-> r_out.active,
                 "frequency change reported while inactive")
    `RFWT_ASSERT(a_result_tracks_state, r_out_valid |-> r_out.freq == r_state.issued_freq,
                 "pending result disagrees with issued frequency")
    `RFWT_ASSERT_NEXT(a_full_blocks_input, r_in_valid && r_out_valid && !m_axis_tready,
                      r_in_valid, "held input beat was dropped")

endmodule

[sv/rfwt_core.sv]
`timescale 1ns / 1ps

module rfwt_core (
    input  rfwt_pkg::t_state                    i_state,
    input  logic [rfwt_pkg::KIND_W-1:0]         i_kind,
    input  logic [rfwt_pkg::FREQ_W-1:0]         i_start_freq,
    input  logic                                i_msg_valid,
    input  logic [rfwt_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [rfwt_pkg::TIME_W-1:0]         i_timeout_ms,
    input  logic [rfwt_pkg::STEP_W-1:0]         i_initial_step,
    output rfwt_pkg::t_state                    o_state,
    output rfwt_pkg::t_result                   o_result
);
    import rfwt_pkg::*;

    always_comb begin
        t_state                     s;
        logic                       tmo;
        logic                       changed;
        logic [TIME_W-1:0]          elapsed;
        logic signed [EDGE_W:0]     half_sum;
        logic signed [EDGE_W-1:0]   mid;
        logic signed [EDGE_W-1:0]   c_outer;
        logic signed [EDGE_W-1:0]   c_inner;
        logic [FREQ_W-1:0]          c_freq;
        logic signed [EDGE_W:0]     diff;
        logic signed [EDGE_W:0]     centre;

        s        = i_state;
        changed  = 1'b0;
        elapsed  = i_now_ms - i_state.last_valid_time;
        tmo      = !i_msg_valid && (elapsed > i_timeout_ms);
        half_sum = div2(sx17(i_state.outer_edge) + sx17(i_state.inner_edge));
        mid      = half_sum[EDGE_W-1:0];

        c_outer = i_state.outer_edge;
        c_inner = i_state.inner_edge;
        c_freq  = i_state.current_freq;
        if (i_msg_valid) begin
            c_inner = mid;
            c_freq  = fadd(i_state.current_freq,
                           div2(sx17(i_state.outer_edge) - sx17(mid)));
        end else if (tmo) begin
            c_outer = mid;
            c_freq  = fadd(i_state.current_freq,
                           -div2(sx17(mid) - sx17(i_state.inner_edge)));
        end
        diff   = sx17(c_outer) - sx17(c_inner);
        centre = div2(sx17(i_state.low_limit) + sx17(c_inner));

        case (i_kind)
            KIND_START: begin
                if (!i_state.enabled) begin
                    s.origin_freq = i_start_freq;
                    s.enabled     = 1'b1;
                end
            end
            KIND_ABORT: begin
                if (i_state.enabled) begin
                    s.phase = PH_ABORT;
                end
            end
            KIND_STEP: begin
                if (i_state.enabled) begin
                    if (i_msg_valid || tmo) begin
                        s.last_valid_time = i_now_ms;
                    end
                    case (i_state.phase)
                        PH_ABORT: begin
                            s.current_freq = i_state.origin_freq;
                            s.phase        = PH_STOP;
                        end
                        PH_STOP: begin
                            s.phase   = PH_IDLE;
                            s.enabled = 1'b0;
                        end
                        PH_IDLE: begin
                            s.step_signed  = signed'(16'd0 - {3'b000, i_initial_step});
                            s.current_freq = i_state.origin_freq;
                            s.phase        = PH_BEGIN;
                        end
                        PH_BEGIN: begin
                            s.inner_edge   = '0;
                            s.outer_edge   = i_state.step_signed;
                            s.current_freq = fadd(i_state.origin_freq,
                                                  sx17(i_state.step_signed));
                            s.phase        = PH_WAIT;
                        end
                        PH_WAIT: begin
                            if (i_msg_valid) begin
                                s.outer_edge   = i_state.outer_edge + i_state.step_signed;
                                s.inner_edge   = i_state.inner_edge + i_state.step_signed;
                                s.current_freq = fadd(i_state.current_freq,
                                                      sx17(i_state.step_signed));
                            end else if (tmo) begin
                                s.current_freq = fadd(i_state.current_freq,
                                                      -div2(sx17(i_state.step_signed)));
                                s.phase        = PH_CHOP;
                            end
                        end
                        PH_CHOP: begin
                            s.outer_edge   = c_outer;
                            s.inner_edge   = c_inner;
                            s.current_freq = c_freq;
                            if (diff <= 17'sd1 && diff >= -17'sd1) begin
                                if (i_state.step_signed < 0) begin
                                    s.low_limit    = c_inner;
                                    s.current_freq = i_state.origin_freq;
                                    s.step_signed  = 16'sd0 - i_state.step_signed;
                                    s.phase        = PH_BEGIN;
                                end else begin
                                    s.high_limit   = c_inner;
                                    s.current_freq = fadd(i_state.origin_freq, centre);
                                    s.phase        = PH_STOP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (s.current_freq != i_state.issued_freq) begin
                        s.issued_freq     = s.current_freq;
                        s.last_valid_time = i_now_ms;
                        changed           = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        o_state          = s;
        o_result.freq    = s.issued_freq;
        o_result.changed = changed;
        o_result.active  = s.enabled;
    end

endmodule

[dv/radio_frequency_window_tuner_unit_tb.sv]
`timescale 1ns / 1ps

module radio_frequency_window_tuner_unit_tb;
    import rfwt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 5000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata = '0;
    logic [KIND_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data = '0;

    radio_frequency_window_tuner_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_len = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int errors = 0;
    int quiet = 0;
    logic [TIME_W-1:0] clock_ms = 32'hFFFF_FFF0;

    t_result expected_tunings[$];

    logic [TIME_W-1:0]  cfg_timeout = TIMEOUT_MS_RESET;
    logic [STEP_W-1:0]  cfg_step = INITIAL_STEP_RESET;
    t_phase             tune_phase = PH_IDLE;
    logic               tune_on = 1'b0;
    logic [FREQ_W-1:0]  origin_freq = '0;
    logic [FREQ_W-1:0]  current_freq = '0;
    logic [FREQ_W-1:0]  issued_freq = '0;
    logic [TIME_W-1:0]  last_ok_ms = '0;
    int                 outer_off = 0;
    int                 inner_off = 0;
    int                 step_off = 0;
    int                 low_off = 0;
    int                 high_off = 0;

    function automatic int fold16(input int v);
        logic signed [EDGE_W-1:0] s;
        s = v[EDGE_W-1:0];
        return s;
    endfunction

    function automatic logic [FREQ_W-1:0] shift_freq(input logic [FREQ_W-1:0] f, input int d);
        return f + d[FREQ_W-1:0];
    endfunction

    task automatic advance_search(input logic valid, input logic tmo);
        int diff;
        case (tune_phase)
            PH_ABORT: begin
                current_freq = origin_freq;
                tune_phase = PH_STOP;
            end
            PH_STOP: begin
                tune_phase = PH_IDLE;
                tune_on = 1'b0;
            end
            PH_IDLE: begin
                step_off = fold16(-int'(cfg_step));
                current_freq = origin_freq;
                tune_phase = PH_BEGIN;
            end
            PH_BEGIN: begin
                inner_off = 0;
                outer_off = step_off;
                current_freq = shift_freq(origin_freq, outer_off);
                tune_phase = PH_WAIT;
            end
            PH_WAIT: begin
                if (valid) begin
                    outer_off = fold16(outer_off + step_off);
                    inner_off = fold16(inner_off + step_off);
                    current_freq = shift_freq(current_freq, step_off);
                end else if (tmo) begin
                    current_freq = shift_freq(current_freq, -(step_off / 2));
                    tune_phase = PH_CHOP;
                end
            end
            PH_CHOP: begin
                if (valid) begin
                    inner_off = fold16((outer_off + inner_off) / 2);
                    current_freq = shift_freq(current_freq, (outer_off - inner_off) / 2);
                end else if (tmo) begin
                    outer_off = fold16((outer_off + inner_off) / 2);
                    current_freq = shift_freq(current_freq, -((outer_off - inner_off) / 2));
                end
                diff = outer_off - inner_off;
                if (diff <= 1 && diff >= -1) begin
                    if (step_off < 0) begin
                        low_off = inner_off;
                        current_freq = origin_freq;
                        step_off = fold16(-step_off);
                        tune_phase = PH_BEGIN;
                    end else begin
                        high_off = inner_off;
                        current_freq = shift_freq(origin_freq, (low_off + high_off) / 2);
                        tune_phase = PH_STOP;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic predict_tuning(input logic [KIND_W-1:0] kind, input logic [FREQ_W-1:0] sf,
                                  input logic valid, input logic [TIME_W-1:0] now);
        logic tmo;
        t_result r;
        r.changed = 1'b0;
        if (kind == KIND_START) begin
            if (!tune_on) begin
                origin_freq = sf;
                tune_on = 1'b1;
            end
        end else if (kind == KIND_ABORT) begin
            if (tune_on) tune_phase = PH_ABORT;
        end else if (kind == KIND_STEP && tune_on) begin
            tmo = !valid && ((now - last_ok_ms) > cfg_timeout);
            if (valid || tmo) last_ok_ms = now;
            advance_search(valid, tmo);
            if (current_freq != issued_freq) begin
                issued_freq = current_freq;
                last_ok_ms = now;
                r.changed = 1'b1;
            end
        end
        r.active = tune_on;
        r.freq = issued_freq;
        expected_tunings.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_tuning(s_axis_tuser, s_axis_tdata[23:0], s_axis_tdata[24],
                               s_axis_tdata[56:25]);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_TIMEOUT_MS:   cfg_timeout = i_cfg_data;
                    REG_INITIAL_STEP: cfg_step = i_cfg_data[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[25:0];
            if (expected_tunings.size() == 0) begin
                $error("result beat with nothing expected: freq %h", got.freq);
                errors++;
            end else begin
                want = expected_tunings.pop_front();
                if (got.freq !== want.freq) begin
                    $error("freq mismatch: expected %h, actual %h", want.freq, got.freq);
                    errors++;
                end
                if (got.changed !== want.changed) begin
                    $error("freq_changed mismatch: expected %b, actual %b",
                           want.changed, got.changed);
                    errors++;
                end
                if (got.active !== want.active) begin
                    $error("tuning_active mismatch: expected %b, actual %b",
                           want.active, got.active);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [FREQ_W-1:0] sf,
                             input logic valid, input logic [TIME_W-1:0] now);
        int gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {7'd0, now, valid, sf};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_step(input logic valid, input logic [TIME_W-1:0] delta);
        clock_ms = clock_ms + delta;
        send_item(KIND_STEP, FREQ_W'($urandom()), valid, clock_ms);
    endtask

    task automatic send_random_step();
        logic ok;
        int r;
        ok = ($urandom_range(99) < 50);
        r = $urandom_range(99);
        if (r < 5) send_step(ok, $urandom());
        else if (!ok && r < 60) send_step(ok, cfg_timeout + $urandom_range(1, 64));
        else send_step(ok, $urandom_range(0, 40));
    endtask

    task automatic wait_for_results(input int settle);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_tunings.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        wait_for_results(4);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_sessions(input int n);
        int sent = 0;
        int r;
        logic [FREQ_W-1:0] f;
        while (sent < n) begin
            if ($urandom_range(99) < 8) begin
                send_item(KIND_W'($urandom_range(3)), FREQ_W'($urandom()),
                          1'($urandom_range(1)), $urandom());
                sent++;
            end else begin
                r = $urandom_range(99);
                f = (r < 5) ? '0 : (r < 10) ? '1 : FREQ_W'($urandom());
                send_item(KIND_START, f, 1'($urandom_range(1)), clock_ms);
                sent++;
                repeat ($urandom_range(4, 48)) begin
                    r = $urandom_range(99);
                    if (r < 3) begin
                        send_item(KIND_ABORT, FREQ_W'($urandom()), 1'($urandom_range(1)),
                                  clock_ms);
                    end else if (r < 5) begin
                        send_item(KIND_START, FREQ_W'($urandom()), 1'($urandom_range(1)),
                                  clock_ms);
                    end else begin
                        send_random_step();
                    end
                    sent++;
                end
                if ($urandom_range(1)) begin
                    send_item(KIND_ABORT, FREQ_W'($urandom()), 1'($urandom_range(1)), clock_ms);
                    repeat (3) send_random_step();
                    sent += 4;
                end
            end
        end
    endtask

    task automatic test_ignored_items();
        send_item(KIND_STEP, '1, 1'b1, '1);
        send_item(KIND_ABORT, '0, 1'b0, '0);
        send_item(KIND_UNUSED, '1, 1'b1, '1);
        send_item(KIND_STEP, '0, 1'b0, '0);
        wait_for_results(4);
    endtask

    task automatic test_directed_search();
        write_reg(REG_TIMEOUT_MS, 32'd1);
        write_reg(REG_INITIAL_STEP, 32'd2);
        send_item(KIND_START, '0, 1'b0, clock_ms);
        send_item(KIND_START, 24'h123456, 1'b1, clock_ms);
        send_step(1'b1, 32'd1);
        send_step(1'b1, 32'd1);
        send_step(1'b1, 32'd1);
        send_step(1'b0, 32'd10);
        send_step(1'b1, 32'd1);
        send_step(1'b0, 32'd10);
        send_step(1'b0, 32'd10);
        send_step(1'b1, 32'd1);
        send_step(1'b0, 32'd10);
        send_step(1'b0, 32'd10);
        send_item(KIND_ABORT, '1, 1'b1, clock_ms);
        send_step(1'b1, 32'd1);
        send_step(1'b1, 32'd1);
        send_step(1'b1, 32'd1);
        wait_for_results(4);
    endtask

    task automatic test_zero_step();
        write_reg(REG_INITIAL_STEP, 32'd0);
        send_item(KIND_START, '1, 1'b0, clock_ms);
        send_step(1'b1, 32'd1);
        send_step(1'b1, 32'd1);
        send_step(1'b1, 32'd1);
        send_step(1'b0, 32'd10);
        send_step(1'b0, 32'd10);
        send_step(1'b0, 32'd10);
        wait_for_results(4);
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        write_reg(REG_TIMEOUT_MS, 32'd20);
        write_reg(REG_INITIAL_STEP, 32'd16);
        hold_len = 80;
        hold_req++;
        run_sessions(40);
        wait_for_results(4);
        run_sessions(20);
        wait_for_results(4);
    endtask

    task automatic test_random_traffic(input int n, input int idle, input int stall,
                                       input logic [CFG_DAT_W-1:0] tmo,
                                       input logic [CFG_DAT_W-1:0] step);
        idle_pct = idle;
        stall_pct = stall;
        write_reg(REG_TIMEOUT_MS, tmo);
        write_reg(REG_INITIAL_STEP, step);
        run_sessions(n);
        wait_for_results(4);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ignored_items();
        test_directed_search();
        test_zero_step();
        test_backpressure();
        test_random_traffic(450, 0, 0, TIMEOUT_MS_RESET, INITIAL_STEP_RESET);
        test_random_traffic(450, 84, 0, 32'd1, 32'd4096);
        test_random_traffic(450, 0, 84, 32'd5000, 32'd8191);
        test_random_traffic(400, 19, 19, $urandom_range(1, 100000), $urandom_range(2, 4096));
        test_random_traffic(150, 19, 19, 32'hFFFF_FFFF, 32'd2);
        wait_for_results(8);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/rfwt_pkg.sv
sv/rfwt_core.sv
sv/radio_frequency_window_tuner_unit.sv
dv/radio_frequency_window_tuner_unit_tb.sv
